// ----- design/assert_macros.svh -----
// Assertion macros shared by the closest-approach RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/tlca_pkg.sv -----
// Shared widths, types and pipeline timing for the closest-approach block.
`default_nettype none
package tlca_pkg;

  // Field widths
  localparam int PT_W      = 32;
  localparam int DIR_W     = 24;
  localparam int SUM_W     = PT_W + 1;           // pa - pb, pa + pb
  localparam int FRAC_BITS = 24;

  // Front-end products and dot-product sums
  localparam int PRD1_W = 2 * DIR_W;             // dir * dir
  localparam int PRD2_W = DIR_W + SUM_W;         // dir * w
  localparam int MAG_W  = 58;                    // dot products, signed / magnitude
  localparam int HALF_W = MAG_W / 2;             // multiplier split point
  localparam int PROD_W = 2 * MAG_W + 1;         // signed product of two dot products

  // Denominator, numerators, quotient
  localparam int DEN_W  = 97;
  localparam int NUM_W  = 108;
  localparam int N_W    = 106;                   // numerator magnitude
  localparam int Q_W    = 63;                    // raw quotient bits, one per divider stage
  localparam int SAT_SH = Q_W - FRAC_BITS - 1;   // n >= den << SAT_SH saturates
  localparam int REM_W  = DEN_W + 1;
  localparam int S_W    = Q_W + 1;               // signed line parameter

  // Pipeline timing: stages before the divider, divider latency
  localparam int LAT_FRONT = 8;
  localparam int DIV_LAT   = Q_W + 3;
  localparam int SB_LAST   = LAT_FRONT + DIV_LAT;

  typedef logic signed [PT_W-1:0]   pt_t;
  typedef logic signed [DIR_W-1:0]  dir_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic signed [MAG_W-1:0]  dot_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [NUM_W-1:0]  num_t;
  typedef logic signed [S_W-1:0]    q_t;

  // Data that rides alongside the arithmetic pipeline
  typedef struct packed {
    logic        vld;
    logic        par;
    pt_t  [2:0]  pa;
    sum_t [2:0]  psum;
    dir_t [2:0]  da;
    dir_t [2:0]  db;
  } side_t;

endpackage
`default_nettype wire

// ----- design/tlca_mul.sv -----
// Three-stage sign/magnitude multiplier for dot-product pairs.
`default_nettype none
module tlca_mul (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic [tlca_pkg::MAG_W-1:0]  a_mag,
  input  wire logic                        a_neg,
  input  wire logic [tlca_pkg::MAG_W-1:0]  b_mag,
  input  wire logic                        b_neg,
  output tlca_pkg::prod_t                  prod
);
  import tlca_pkg::*;

  logic [2*HALF_W-1:0] pp0_r, pp1_r, pp2_r, pp3_r;
  logic                neg1_r, neg2_r;
  logic [2*MAG_W-1:0]  sum_r;
  logic [2*MAG_W-1:0]  mid;
  logic [2*MAG_W-1:0]  sum_nxt;
  logic [PROD_W-1:0]   ext;
  prod_t               prod_r;

  // Partial-product combine
  always_comb begin
    mid     = (2*MAG_W)'(pp1_r) + (2*MAG_W)'(pp2_r);
    sum_nxt = {pp3_r, pp0_r} + (mid << HALF_W);
    ext     = {1'b0, sum_r};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // partial products, each HALF_W x HALF_W
      pp0_r  <= a_mag[HALF_W-1:0] * b_mag[HALF_W-1:0];
      pp1_r  <= a_mag[HALF_W-1:0] * b_mag[MAG_W-1:HALF_W];
      pp2_r  <= a_mag[MAG_W-1:HALF_W] * b_mag[HALF_W-1:0];
      pp3_r  <= a_mag[MAG_W-1:HALF_W] * b_mag[MAG_W-1:HALF_W];
      neg1_r <= a_neg ^ b_neg;
      sum_r  <= sum_nxt;
      neg2_r <= neg1_r;
      prod_r <= neg2_r ? -$signed(ext) : $signed(ext);
    end
  end

  assign prod = prod_r;

endmodule
`default_nettype wire

// ----- design/tlca_div.sv -----
// Pipelined restoring divider: rounded, saturated Q.24 line parameter.
`default_nettype none
`include "assert_macros.svh"
module tlca_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       en,
  input  wire logic                       in_vld,
  input  wire logic [tlca_pkg::N_W-1:0]   n_mag,
  input  wire logic                       n_neg,
  input  wire logic [tlca_pkg::DEN_W-1:0] den,
  output tlca_pkg::q_t                    q_out
);
  import tlca_pkg::*;

  localparam logic [Q_W-1:0] CAP = Q_W'(1) << (Q_W-1);

  logic                v_r   [0:Q_W];
  logic                sat_r [0:Q_W];
  logic                neg_r [0:Q_W];
  logic [DEN_W-1:0]    den_r [0:Q_W];
  logic [DEN_W-1:0]    rem_r [0:Q_W];
  logic [Q_W-1:0]      q_r   [0:Q_W];
  logic [SAT_SH-1:0]   nlo_r [0:Q_W];

  logic                bit_c [Q_W];
  logic [REM_W-1:0]    sh_c  [Q_W];
  logic                ge_c  [Q_W];
  logic [DEN_W-1:0]    rem_c [Q_W];
  logic [REM_W-1:0]    dif_c [Q_W];

  logic                sat_nxt;
  logic [Q_W:0]        qp1;
  logic                vr1_r;
  logic                neg1_r;
  logic [Q_W-1:0]      mag1_r;
  logic [S_W-1:0]      mag_ext;
  q_t                  q_out_r;

  // Overflow check: quotient would need more than Q_W bits
  assign sat_nxt = ({{(N_W-DEN_W){1'b0}}, den} <= (n_mag >> SAT_SH));

  // One quotient bit per stage; low numerator bits enter MSB first
  always_comb begin
    for (int k = 0; k < Q_W; k++) begin
      if (k < SAT_SH) begin
        bit_c[k] = nlo_r[k][SAT_SH-1];
      end else begin
        bit_c[k] = 1'b0;
      end
      sh_c[k]  = {rem_r[k], bit_c[k]};
      dif_c[k] = sh_c[k] - {1'b0, den_r[k]};
      ge_c[k]  = (sh_c[k] >= {1'b0, den_r[k]});
      rem_c[k] = ge_c[k] ? dif_c[k][DEN_W-1:0] : sh_c[k][DEN_W-1:0];
    end
  end

  // Round half away from zero, then restore sign
  always_comb begin
    qp1     = {1'b0, q_r[Q_W]} + (Q_W+1)'(1);
    mag_ext = {1'b0, mag1_r};
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= Q_W; k++) begin
        v_r[k] <= 1'b0;
      end
      vr1_r <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_vld;
      for (int k = 0; k < Q_W; k++) begin
        v_r[k+1] <= v_r[k];
      end
      vr1_r <= v_r[Q_W];
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (en) begin
      sat_r[0] <= sat_nxt;
      neg_r[0] <= n_neg;
      den_r[0] <= den;
      rem_r[0] <= DEN_W'(n_mag >> SAT_SH);
      q_r[0]   <= '0;
      nlo_r[0] <= n_mag[SAT_SH-1:0];
      for (int k = 0; k < Q_W; k++) begin
        sat_r[k+1] <= sat_r[k];
        neg_r[k+1] <= neg_r[k];
        den_r[k+1] <= den_r[k];
        rem_r[k+1] <= rem_c[k];
        q_r[k+1]   <= {q_r[k][Q_W-2:0], ge_c[k]};
        nlo_r[k+1] <= nlo_r[k] << 1;
      end
      mag1_r  <= sat_r[Q_W] ? CAP : qp1[Q_W:1];
      neg1_r  <= neg_r[Q_W];
      q_out_r <= neg1_r ? -$signed(mag_ext) : $signed(mag_ext);
    end
  end

  assign q_out = q_out_r;

  `ASSERT_IMPL(a_mag_cap, vr1_r, mag1_r <= CAP, "line parameter above saturation cap")
  `ASSERT_IMPL(a_rem_lt_den, v_r[Q_W] && !sat_r[Q_W] && (den_r[Q_W] != '0),
    rem_r[Q_W] < den_r[Q_W], "divider remainder not below denominator")

endmodule
`default_nettype wire

// ----- design/tlca_vtx.sv -----
// Vertex stage: s*da + t*db, midpoint rounding, saturation, output register.
`default_nettype none
module tlca_vtx (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           en,
  input  wire tlca_pkg::side_t side,
  input  wire tlca_pkg::q_t   s_q,
  input  wire tlca_pkg::q_t   t_q,
  output logic                out_valid,
  output tlca_pkg::pt_t       vertex_x,
  output tlca_pkg::pt_t       vertex_y,
  output tlca_pkg::pt_t       vertex_z,
  output logic                parallel_flag
);
  import tlca_pkg::*;

  localparam int SL_W  = S_W / 2;
  localparam int LO_W  = SL_W + 1 + DIR_W;
  localparam int HI_W  = S_W - SL_W + DIR_W;
  localparam int SP_W  = S_W + DIR_W;
  localparam int ACC_W = SP_W + 2;

  typedef logic signed [LO_W-1:0]  lo_t;
  typedef logic signed [HI_W-1:0]  hi_t;
  typedef logic signed [SP_W-1:0]  sp_t;
  typedef logic signed [ACC_W-1:0] acc_t;

  localparam acc_t HALF   = acc_t'(1) <<< FRAC_BITS;
  localparam acc_t PT_MAX = (acc_t'(1) <<< (PT_W-1)) - acc_t'(1);
  localparam acc_t PT_MIN = -(acc_t'(1) <<< (PT_W-1));

  lo_t   slo [3], tlo [3];
  hi_t   shi [3], thi [3];
  lo_t   slo_r [3], tlo_r [3];
  hi_t   shi_r [3], thi_r [3];
  sp_t   sp_r [3], tp_r [3];
  acc_t  acc_r [3];
  acc_t  rnd [3];
  pt_t   res [3];
  sum_t  psum1_r [3], psum2_r [3];
  pt_t   pa1_r [3], pa2_r [3], pa3_r [3];
  logic  par1_r, par2_r, par3_r;
  logic  v1_r, v2_r, v3_r, out_valid_r;
  pt_t   vtx_r [3];
  logic  par_out_r;

  // Split s and t into signed high and unsigned low halves
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      slo[k] = $signed({1'b0, s_q[SL_W-1:0]}) * $signed(side.da[k]);
      shi[k] = $signed(s_q[S_W-1:SL_W]) * $signed(side.da[k]);
      tlo[k] = $signed({1'b0, t_q[SL_W-1:0]}) * $signed(side.db[k]);
      thi[k] = $signed(t_q[S_W-1:SL_W]) * $signed(side.db[k]);
    end
  end

  // Divide by 2^(FRAC_BITS+1) and clamp to the coordinate range
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rnd[k] = acc_r[k] >>> (FRAC_BITS + 1);
      if (rnd[k] > PT_MAX) begin
        res[k] = PT_MAX[PT_W-1:0];
      end else if (rnd[k] < PT_MIN) begin
        res[k] = PT_MIN[PT_W-1:0];
      end else begin
        res[k] = rnd[k][PT_W-1:0];
      end
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= side.vld;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        slo_r[k]   <= slo[k];
        shi_r[k]   <= shi[k];
        tlo_r[k]   <= tlo[k];
        thi_r[k]   <= thi[k];
        psum1_r[k] <= side.psum[k];
        pa1_r[k]   <= side.pa[k];

        sp_r[k]    <= (sp_t'(shi_r[k]) <<< SL_W) + sp_t'(slo_r[k]);
        tp_r[k]    <= (sp_t'(thi_r[k]) <<< SL_W) + sp_t'(tlo_r[k]);
        psum2_r[k] <= psum1_r[k];
        pa2_r[k]   <= pa1_r[k];

        acc_r[k]   <= (acc_t'(psum2_r[k]) <<< FRAC_BITS) + acc_t'(sp_r[k])
                      + acc_t'(tp_r[k]) + HALF;
        pa3_r[k]   <= pa2_r[k];

        vtx_r[k]   <= par3_r ? pa3_r[k] : res[k];
      end
      par1_r    <= side.par;
      par2_r    <= par1_r;
      par3_r    <= par2_r;
      par_out_r <= par3_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign vertex_x      = vtx_r[0];
  assign vertex_y      = vtx_r[1];
  assign vertex_z      = vtx_r[2];
  assign parallel_flag = par_out_r;

endmodule
`default_nettype wire

// ----- design/two_line_closest_approach.sv -----
// Closest approach of two 3D lines: fully pipelined vertex unit, top level.
//
// Takes one pair of lines (point and direction each) per cycle and returns the
// midpoint of their shortest connecting segment, rounded and saturated to 32
// bits; a zero denominator (parallel lines or a zero direction) returns the
// first point with parallel_flag set. Throughput is one request per cycle
// while the output is read. Front-end stages form the dot products, the 2x2
// determinant and the two numerators, each line parameter then passes through
// a divider (an input stage, 63 stages that resolve one quotient bit each, and
// two rounding stages), and 4 stages form the vertex.
// The whole pipeline advances together; when a result waits at the output
// unread, the pipeline holds and in_ready drops until it is taken. There is no
// internal state between requests.
`default_nettype none
`include "assert_macros.svh"
module two_line_closest_approach (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire tlca_pkg::pt_t  in_point_a_x,
  input  wire tlca_pkg::pt_t  in_point_a_y,
  input  wire tlca_pkg::pt_t  in_point_a_z,
  input  wire tlca_pkg::dir_t in_dir_a_x,
  input  wire tlca_pkg::dir_t in_dir_a_y,
  input  wire tlca_pkg::dir_t in_dir_a_z,
  input  wire tlca_pkg::pt_t  in_point_b_x,
  input  wire tlca_pkg::pt_t  in_point_b_y,
  input  wire tlca_pkg::pt_t  in_point_b_z,
  input  wire tlca_pkg::dir_t in_dir_b_x,
  input  wire tlca_pkg::dir_t in_dir_b_y,
  input  wire tlca_pkg::dir_t in_dir_b_z,
  output logic                out_valid,
  input  wire logic           out_ready,
  output tlca_pkg::pt_t       out_vertex_x,
  output tlca_pkg::pt_t       out_vertex_y,
  output tlca_pkg::pt_t       out_vertex_z,
  output logic                out_parallel_flag
);
  import tlca_pkg::*;

  typedef logic signed [PRD1_W-1:0] prd1_t;
  typedef logic signed [PRD2_W-1:0] prd2_t;

  logic   adv;
  side_t  sb_r [0:SB_LAST];
  side_t  sb0_nxt, sb8_nxt;
  pt_t    pa_in [3], pb_in [3];
  dir_t   da_in [3], db_in [3];
  sum_t   w_r [3];

  prd1_t  paa_r [3], pab_r [3], pbb_r [3];
  prd2_t  paw_r [3], pbw_r [3];
  dot_t   a_r, b_r, c_r, d_r, e_r;
  logic [MAG_W-1:0] am_r, bm_r, cm_r, dm_r, em_r;
  logic   bs_r, ds_r, es_r;

  prod_t  ac, bb, be, cd, ae, bd;
  prod_t  den_full, ns_full, nt_full;
  logic [DEN_W-1:0] den_r, den8_r;
  num_t   ns_r, nt_r, ns_neg, nt_neg;
  logic [N_W-1:0]   nsm_r, ntm_r;
  logic   nss_r, nts_r;
  q_t     s_q, t_q;

  // Global advance: the output register is empty or being read
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  assign pa_in[0] = in_point_a_x;
  assign pa_in[1] = in_point_a_y;
  assign pa_in[2] = in_point_a_z;
  assign pb_in[0] = in_point_b_x;
  assign pb_in[1] = in_point_b_y;
  assign pb_in[2] = in_point_b_z;
  assign da_in[0] = in_dir_a_x;
  assign da_in[1] = in_dir_a_y;
  assign da_in[2] = in_dir_a_z;
  assign db_in[0] = in_dir_b_x;
  assign db_in[1] = in_dir_b_y;
  assign db_in[2] = in_dir_b_z;

  // Sideband entering the pipe; parallel flag joins after the determinant
  always_comb begin
    sb0_nxt     = '0;
    sb0_nxt.vld = in_valid;
    for (int k = 0; k < 3; k++) begin
      sb0_nxt.pa[k]   = pa_in[k];
      sb0_nxt.psum[k] = sum_t'(pa_in[k]) + sum_t'(pb_in[k]);
      sb0_nxt.da[k]   = da_in[k];
      sb0_nxt.db[k]   = db_in[k];
    end
    sb8_nxt     = sb_r[LAT_FRONT-1];
    sb8_nxt.par = (den_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= SB_LAST; k++) begin
        sb_r[k].vld <= 1'b0;
      end
    end else if (adv) begin
      sb_r[0] <= sb0_nxt;
      for (int k = 1; k <= SB_LAST; k++) begin
        if (k == LAT_FRONT) begin
          sb_r[k] <= sb8_nxt;
        end else begin
          sb_r[k] <= sb_r[k-1];
        end
      end
    end
  end

  // Front end: w, element products, dot products, magnitudes
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        w_r[k]   <= sum_t'(pa_in[k]) - sum_t'(pb_in[k]);
        paa_r[k] <= $signed(sb_r[0].da[k]) * $signed(sb_r[0].da[k]);
        pab_r[k] <= $signed(sb_r[0].da[k]) * $signed(sb_r[0].db[k]);
        pbb_r[k] <= $signed(sb_r[0].db[k]) * $signed(sb_r[0].db[k]);
        paw_r[k] <= $signed(sb_r[0].da[k]) * w_r[k];
        pbw_r[k] <= $signed(sb_r[0].db[k]) * w_r[k];
      end
      a_r <= dot_t'(paa_r[0]) + dot_t'(paa_r[1]) + dot_t'(paa_r[2]);
      b_r <= dot_t'(pab_r[0]) + dot_t'(pab_r[1]) + dot_t'(pab_r[2]);
      c_r <= dot_t'(pbb_r[0]) + dot_t'(pbb_r[1]) + dot_t'(pbb_r[2]);
      d_r <= dot_t'(paw_r[0]) + dot_t'(paw_r[1]) + dot_t'(paw_r[2]);
      e_r <= dot_t'(pbw_r[0]) + dot_t'(pbw_r[1]) + dot_t'(pbw_r[2]);

      // a and c are sums of squares, never negative
      am_r <= a_r;
      cm_r <= c_r;
      bm_r <= b_r[MAG_W-1] ? -b_r : b_r;
      dm_r <= d_r[MAG_W-1] ? -d_r : d_r;
      em_r <= e_r[MAG_W-1] ? -e_r : e_r;
      bs_r <= b_r[MAG_W-1];
      ds_r <= d_r[MAG_W-1];
      es_r <= e_r[MAG_W-1];
    end
  end

  // Products of dot products
  tlca_mul u_mul_ac (.clk, .en(adv), .a_mag(am_r), .a_neg(1'b0),
                     .b_mag(cm_r), .b_neg(1'b0), .prod(ac));
  tlca_mul u_mul_bb (.clk, .en(adv), .a_mag(bm_r), .a_neg(bs_r),
                     .b_mag(bm_r), .b_neg(bs_r), .prod(bb));
  tlca_mul u_mul_be (.clk, .en(adv), .a_mag(bm_r), .a_neg(bs_r),
                     .b_mag(em_r), .b_neg(es_r), .prod(be));
  tlca_mul u_mul_cd (.clk, .en(adv), .a_mag(cm_r), .a_neg(1'b0),
                     .b_mag(dm_r), .b_neg(ds_r), .prod(cd));
  tlca_mul u_mul_ae (.clk, .en(adv), .a_mag(am_r), .a_neg(1'b0),
                     .b_mag(em_r), .b_neg(es_r), .prod(ae));
  tlca_mul u_mul_bd (.clk, .en(adv), .a_mag(bm_r), .a_neg(bs_r),
                     .b_mag(dm_r), .b_neg(ds_r), .prod(bd));

  // Determinant and numerators, then numerator magnitudes
  always_comb begin
    den_full = ac - bb;
    ns_full  = be - cd;
    nt_full  = ae - bd;
    ns_neg   = -ns_r;
    nt_neg   = -nt_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      den_r  <= den_full[DEN_W-1:0];
      ns_r   <= ns_full[NUM_W-1:0];
      nt_r   <= nt_full[NUM_W-1:0];
      den8_r <= den_r;
      nsm_r  <= ns_r[NUM_W-1] ? ns_neg[N_W-1:0] : ns_r[N_W-1:0];
      ntm_r  <= nt_r[NUM_W-1] ? nt_neg[N_W-1:0] : nt_r[N_W-1:0];
      nss_r  <= ns_r[NUM_W-1];
      nts_r  <= nt_r[NUM_W-1];
    end
  end

  // Line parameters s and t
  tlca_div u_div_s (.clk, .rst_n, .en(adv), .in_vld(sb_r[LAT_FRONT].vld),
                    .n_mag(nsm_r), .n_neg(nss_r), .den(den8_r), .q_out(s_q));
  tlca_div u_div_t (.clk, .rst_n, .en(adv), .in_vld(sb_r[LAT_FRONT].vld),
                    .n_mag(ntm_r), .n_neg(nts_r), .den(den8_r), .q_out(t_q));

  // Vertex and output register
  tlca_vtx u_vtx (
    .clk,
    .rst_n,
    .en            (adv),
    .side          (sb_r[SB_LAST]),
    .s_q           (s_q),
    .t_q           (t_q),
    .out_valid     (out_valid),
    .vertex_x      (out_vertex_x),
    .vertex_y      (out_vertex_y),
    .vertex_z      (out_vertex_z),
    .parallel_flag (out_parallel_flag)
  );

  `ASSERT_IMPL(a_den_nonneg, sb_r[LAT_FRONT-2].vld, !den_full[PROD_W-1],
    "determinant negative")
  `ASSERT_NEXT(a_stall_hold, sb_r[SB_LAST].vld && !adv, sb_r[SB_LAST].vld,
    "request at divider output lost during stall")

endmodule
`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// Testbench for the two-line closest-approach vertex unit.
`timescale 1ns / 100ps
module tb_top;
  import tlca_pkg::*;

  localparam int N_RAND   = 1400;
  localparam int CALM_TAIL = 150;   // final requests sent with no idling
  localparam int DRAIN    = 120;    // wait after the expected-result queue empties

  typedef struct packed {
    pt_t  pax, pay, paz;
    dir_t dax, day, daz;
    pt_t  pbx, pby, pbz;
    dir_t dbx, dby, dbz;
  } line_pair_t;

  typedef struct packed {
    pt_t  x, y, z;
    logic par;
  } vertex_t;

  typedef struct packed {
    line_pair_t lp;
    logic       known;
    vertex_t    want;
  } row_t;

  localparam pt_t  PMAX = 32'sh7FFFFFFF;
  localparam pt_t  PMIN = 32'sh80000000;
  localparam dir_t DMAX = 24'sh7FFFFF;
  localparam dir_t DMIN = 24'sh800000;

  logic       clk, rst_n;
  logic       in_valid, in_ready, out_valid, out_ready;
  line_pair_t req;
  pt_t        out_vertex_x, out_vertex_y, out_vertex_z;
  logic       out_parallel_flag;
  bit         failed, calm;
  vertex_t    vertex_q[$];

  two_line_closest_approach i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_point_a_x(req.pax), .in_point_a_y(req.pay), .in_point_a_z(req.paz),
    .in_dir_a_x(req.dax), .in_dir_a_y(req.day), .in_dir_a_z(req.daz),
    .in_point_b_x(req.pbx), .in_point_b_y(req.pby), .in_point_b_z(req.pbz),
    .in_dir_b_x(req.dbx), .in_dir_b_y(req.dby), .in_dir_b_z(req.dbz),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_vertex_x(out_vertex_x), .out_vertex_y(out_vertex_y),
    .out_vertex_z(out_vertex_z), .out_parallel_flag(out_parallel_flag)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // Line parameter: num * 2^24 / den rounded half away from zero, magnitude capped at 2^62
  function automatic logic signed [127:0] line_param(logic signed [127:0] num,
                                                     logic signed [127:0] den);
    logic [127:0] un;
    logic [255:0] qq;
    logic [127:0] m;
    un = num[127] ? -num : num;
    qq = ({128'b0, un} << 25) / {128'b0, den};
    if (qq >= (256'd1 << 63)) m = 128'd1 << 62;
    else m = (qq[127:0] + 128'd1) >> 1;
    return num[127] ? -$signed(m) : $signed(m);
  endfunction

  // Midpoint on one axis: round half up by 2^25, saturate to 32 bits
  function automatic pt_t vertex_axis(logic signed [127:0] pa, logic signed [127:0] pb,
                                      logic signed [127:0] s, logic signed [127:0] da,
                                      logic signed [127:0] t, logic signed [127:0] db);
    logic signed [127:0] acc;
    acc = ((pa + pb) <<< 24) + s * da + t * db + (128'sd1 <<< 24);
    acc = acc >>> 25;
    if (acc > 128'sd2147483647) return PMAX;
    if (acc < -128'sd2147483648) return PMIN;
    return pt_t'(acc[31:0]);
  endfunction

  // Closest-approach vertex of two lines
  function automatic vertex_t closest_vertex(line_pair_t lp);
    logic signed [127:0] pa[3], pb[3], da[3], db[3], w;
    logic signed [127:0] a, b, c, d, e, den, s, t;
    vertex_t v;
    pa = '{lp.pax, lp.pay, lp.paz};
    pb = '{lp.pbx, lp.pby, lp.pbz};
    da = '{lp.dax, lp.day, lp.daz};
    db = '{lp.dbx, lp.dby, lp.dbz};
    a = 0; b = 0; c = 0; d = 0; e = 0;
    for (int k = 0; k < 3; k++) begin
      w = pa[k] - pb[k];
      a += da[k] * da[k];
      b += da[k] * db[k];
      c += db[k] * db[k];
      d += da[k] * w;
      e += db[k] * w;
    end
    den = a * c - b * b;
    if (den == 0) begin
      v = '{lp.pax, lp.pay, lp.paz, 1'b1};
    end else begin
      s = line_param(b * e - c * d, den);
      t = line_param(a * e - b * d, den);
      v.x = vertex_axis(pa[0], pb[0], s, da[0], t, db[0]);
      v.y = vertex_axis(pa[1], pb[1], s, da[1], t, db[1]);
      v.z = vertex_axis(pa[2], pb[2], s, da[2], t, db[2]);
      v.par = 1'b0;
    end
    return v;
  endfunction

  function automatic dir_t rand_dir(int kind);
    case (kind)
      0: return dir_t'($signed($urandom_range(0, 6)) - 3);
      1: return dir_t'($signed($urandom_range(0, 2000)) - 1000);
      default: return dir_t'($urandom());
    endcase
  endfunction

  function automatic pt_t rand_pt(int kind);
    if (kind < 2) return pt_t'($signed($urandom_range(0, 200000)) - 100000);
    return pt_t'($urandom());
  endfunction

  // Random line pair; some pairs parallel or with a zero direction
  function automatic line_pair_t rand_pair();
    line_pair_t lp;
    int dk, pk, m;
    dk = $urandom_range(0, 4);
    pk = $urandom_range(0, 3);
    lp.pax = rand_pt(pk); lp.pay = rand_pt(pk); lp.paz = rand_pt(pk);
    lp.pbx = rand_pt(pk); lp.pby = rand_pt(pk); lp.pbz = rand_pt(pk);
    lp.dax = rand_dir(dk); lp.day = rand_dir(dk); lp.daz = rand_dir(dk);
    lp.dbx = rand_dir(dk); lp.dby = rand_dir(dk); lp.dbz = rand_dir(dk);
    case ($urandom_range(0, 9))
      0: begin
        // parallel: second direction a small multiple of the first
        m = $signed($urandom_range(0, 6)) - 3;
        lp.dax = rand_dir(1); lp.day = rand_dir(1); lp.daz = rand_dir(1);
        lp.dbx = dir_t'(lp.dax * m);
        lp.dby = dir_t'(lp.day * m);
        lp.dbz = dir_t'(lp.daz * m);
      end
      1: begin
        lp.dbx = lp.dax; lp.dby = lp.day; lp.dbz = lp.daz;
      end
      2: if ($urandom_range(0, 1)) {lp.dax, lp.day, lp.daz} = '0;
         else {lp.dbx, lp.dby, lp.dbz} = '0;
      default: ;
    endcase
    return lp;
  endfunction

  // Directed requests; the vertex is typed in only where it is obvious
  row_t dir_tab[] = '{
    '{'{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, '{0, 0, 0, 1'b1}},
    '{'{PMAX, PMIN, PMAX, 0, 0, 0, PMIN, PMAX, PMIN, 1, 2, 3}, 1'b1,
      '{PMAX, PMIN, PMAX, 1'b1}},
    '{'{PMIN, PMAX, -1, 5, 6, 7, 0, 0, 0, 0, 0, 0}, 1'b1, '{PMIN, PMAX, -1, 1'b1}},
    '{'{7, -9, 11, DMAX, DMAX, DMAX, PMAX, PMAX, PMAX, DMAX, DMAX, DMAX}, 1'b1,
      '{7, -9, 11, 1'b1}},
    '{'{-3, 4, 5, DMIN, DMIN, DMIN, 1, 1, 1, DMAX, DMAX, DMAX}, 1'b0, '0},
    '{'{0, 0, 5, 1, 0, 0, 0, 0, -5, 0, 1, 0}, 1'b1, '{0, 0, 0, 1'b0}},
    '{'{0, 0, 100, 1, 0, 0, 0, 0, -100, 0, 1, 0}, 1'b1, '{0, 0, 0, 1'b0}},
    '{'{PMAX, PMAX, PMAX, DMAX, 0, 0, PMAX, PMAX, PMIN, 0, DMAX, 0}, 1'b0, '0},
    '{'{PMIN, PMIN, PMIN, DMIN, 0, 0, PMIN, PMIN, PMAX, 0, DMIN, 0}, 1'b0, '0},
    '{'{PMAX, PMIN, 0, DMAX, DMIN, 1, PMIN, PMAX, 0, DMIN, DMIN, -1}, 1'b0, '0},
    '{'{PMIN, PMIN, PMIN, 1, 0, 0, PMAX, PMAX, PMAX, 0, 1, 1}, 1'b0, '0},
    '{'{PMAX, PMAX, PMAX, 1, 1, 0, PMIN, PMIN, PMIN, 0, 0, 1}, 1'b0, '0},
    '{'{0, 0, 0, 1, 0, 0, 0, 1, 0, DMAX, 1, 0}, 1'b0, '0},
    '{'{-1, -1, -1, DMIN, DMAX, DMIN, 1, 1, 1, DMAX, DMIN, DMAX}, 1'b0, '0}
  };

  // Expectation per accepted request
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) vertex_q.push_back(closest_vertex(req));
  end

  // Result checker
  always @(posedge clk) begin
    vertex_t want;
    if (rst_n && out_valid && out_ready) begin
      if (vertex_q.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d z=%0d par=%0b", $time,
                 out_vertex_x, out_vertex_y, out_vertex_z, out_parallel_flag);
        failed = 1'b1;
      end else begin
        want = vertex_q.pop_front();
        if (out_vertex_x !== want.x) begin
          $display("%0t: vertex_x exp %0d act %0d", $time, want.x, out_vertex_x);
          failed = 1'b1;
        end
        if (out_vertex_y !== want.y) begin
          $display("%0t: vertex_y exp %0d act %0d", $time, want.y, out_vertex_y);
          failed = 1'b1;
        end
        if (out_vertex_z !== want.z) begin
          $display("%0t: vertex_z exp %0d act %0d", $time, want.z, out_vertex_z);
          failed = 1'b1;
        end
        if (out_parallel_flag !== want.par) begin
          $display("%0t: parallel_flag exp %0b act %0b", $time, want.par,
                   out_parallel_flag);
          failed = 1'b1;
        end
      end
    end
  end

  // Receiver backpressure in bursts
  initial begin
    int n;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      out_ready = 1'b1;
      if (!calm && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 12);
        out_ready = 1'b0;
        repeat (n) @(negedge clk);
        out_ready = 1'b1;
      end
      repeat ($urandom_range(0, 20)) @(negedge clk);
    end
  end

  task automatic send_request(line_pair_t lp);
    int n;
    if (!calm && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 12);
      in_valid = 1'b0;
      repeat (n) @(negedge clk);
    end
    req = lp;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Stimulus: directed table, then random pairs, then drain
  initial begin
    int wait_cnt;
    vertex_t got;
    failed = 1'b0;
    calm = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    req = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    foreach (dir_tab[i]) begin
      got = closest_vertex(dir_tab[i].lp);
      if (dir_tab[i].known && got != dir_tab[i].want) begin
        $display("%0t: directed row %0d exp x=%0d y=%0d z=%0d par=%0b", $time, i,
                 dir_tab[i].want.x, dir_tab[i].want.y, dir_tab[i].want.z,
                 dir_tab[i].want.par);
        $display("%0t: directed row %0d act x=%0d y=%0d z=%0d par=%0b", $time, i,
                 got.x, got.y, got.z, got.par);
        failed = 1'b1;
      end
      send_request(dir_tab[i].lp);
    end
    for (int i = 0; i < N_RAND; i++) begin
      calm = (i >= N_RAND - CALM_TAIL);
      send_request(rand_pair());
    end
    in_valid = 1'b0;
    wait_cnt = 0;
    while (vertex_q.size() != 0 && wait_cnt < 100000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (DRAIN) @(posedge clk);
    if (!failed && vertex_q.size() == 0)
      $display("** two_line_closest_approach: PASSED **");
    else
      $display("** two_line_closest_approach: FAILED **");
    $finish;
  end

  // Watchdog
  initial begin
    #20ms;
    $display("** two_line_closest_approach: FAILED **");
    $finish;
  end

endmodule
